### hw/rtl/ohash_pkg.sv
`default_nettype none
package ohash_pkg;

  // request modes
  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam int KEY_BITS = 16;
  localparam int NFV_BITS = 32;

  // request as it travels from front to back
  typedef struct packed {
    mode_t                mode;
    logic [KEY_BITS-1:0]  key;
    logic [63:0]          value;
    // fractional part of key times the depth reciprocal, gives the home slot
    logic [31:0]          home_frac;
  } req_t;

endpackage
`default_nettype wire

### hw/rtl/ohash_front.sv
`default_nettype none
// request intake: accepts transactions and holds them in a short queue
module ohash_front #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire ohash_pkg::mode_t               mode,
  input  wire logic [ohash_pkg::KEY_BITS-1:0] lookup_key,
  input  wire logic [VALUE_BITS-1:0]          entry_value,
  output logic                                req_valid,
  output ohash_pkg::req_t                     req,
  input  wire logic                           req_take
);

  // rounded-up reciprocal of the depth, exact for 16-bit keys
  localparam logic [63:0] HOME_RECIP =
    (64'h1_0000_0000 + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);

  // two-entry queue
  ohash_pkg::req_t q [2];
  logic            rd_ptr;
  logic            wr_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;
  ohash_pkg::req_t incoming;
  logic [63:0]     frac_wide;

  assign full      = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;
  assign frac_wide = 64'(lookup_key) * HOME_RECIP;

  // classify and widen the value, masked to its width
  always_comb begin
    incoming       = '0;
    incoming.mode  = mode;
    incoming.key   = lookup_key;
    incoming.value[VALUE_BITS-1:0] = entry_value;
    incoming.home_frac = frac_wide[31:0];
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= incoming;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ohash_back.sv
`default_nettype none
// probe engine: walks the slot memory one probe per pass, holds one result
module ohash_back #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  input  wire ohash_pkg::req_t                req,
  output logic                                req_take,
  input  wire logic [ohash_pkg::NFV_BITS-1:0] nfv,
  output logic                                empty,
  input  wire logic                           pop,
  output ohash_pkg::status_t                  status,
  output logic [ohash_pkg::NFV_BITS-1:0]      found_value
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [1:0] MK_EMPTY   = 2'd0;
  localparam logic [1:0] MK_ACTIVE  = 2'd1;
  localparam logic [1:0] MK_DELETED = 2'd2;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_CHECK, S_CLEAR, S_OUT
  } state_t;

  // slot memories
  logic [1:0]                      marks  [TABLE_DEPTH];
  logic [ohash_pkg::KEY_BITS-1:0]  keys   [TABLE_DEPTH];
  logic [VALUE_BITS-1:0]           vals   [TABLE_DEPTH];

  state_t                          state;
  ohash_pkg::req_t                 cur;
  logic [AW-1:0]                   pos;
  logic [CW-1:0]                   visits;
  logic [1:0]                      rd_mark;
  logic [ohash_pkg::KEY_BITS-1:0]  rd_key;
  logic [VALUE_BITS-1:0]           rd_val;
  logic                            mk_we;
  logic [1:0]                      mk_wd;
  logic [AW-1:0]                   mk_wa;
  logic                            kv_we;
  logic [AW-1:0]                   pos_next;
  logic [63:0]                     rd_val_wide;
  logic [63:0]                     home_prod;

  assign req_take = (state == S_IDLE) && req_valid;
  assign empty    = (state != S_OUT);
  assign pos_next = (pos == AW'(TABLE_DEPTH - 1)) ? '0 : pos + 1'b1;
  // home slot: integer part of the fraction scaled by the depth
  assign home_prod = 64'(req.home_frac) * 64'(TABLE_DEPTH);
  always_comb begin
    rd_val_wide = '0;
    rd_val_wide[VALUE_BITS-1:0] = rd_val;
  end

  // memory write controls
  always_comb begin
    mk_we = 1'b0;
    mk_wd = MK_EMPTY;
    mk_wa = pos;
    kv_we = 1'b0;
    unique case (state)
      S_INIT, S_CLEAR: mk_we = 1'b1;
      S_CHECK: begin
        if (rd_mark == MK_EMPTY || rd_key == cur.key) begin
          if (cur.mode == ohash_pkg::MODE_INSERT && rd_mark != MK_ACTIVE) begin
            mk_we = 1'b1;
            mk_wd = MK_ACTIVE;
            kv_we = 1'b1;
          end else if (cur.mode == ohash_pkg::MODE_REMOVE && rd_mark == MK_ACTIVE) begin
            mk_we = 1'b1;
            mk_wd = MK_DELETED;
          end
        end
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (mk_we) marks[mk_wa] <= mk_wd;
    if (kv_we) begin
      keys[pos] <= cur.key;
      vals[pos] <= cur.value[VALUE_BITS-1:0];
    end
    rd_mark <= marks[pos];
    rd_key  <= keys[pos];
    rd_val  <= vals[pos];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      pos    <= '0;
      visits <= '0;
    end else begin
      unique case (state)
        // clearing pass after reset
        S_INIT: begin
          pos <= pos_next;
          if (pos == AW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur    <= req;
            visits <= '0;
            if (req.mode == ohash_pkg::MODE_CLEAR) begin
              pos   <= '0;
              state <= S_CLEAR;
            end else begin
              pos   <= home_prod[32 +: AW];
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          found_value <= nfv;
          status      <= ohash_pkg::ST_DONE;
          if (rd_mark == MK_EMPTY || rd_key == cur.key) begin
            state <= S_OUT;
            unique case (cur.mode)
              ohash_pkg::MODE_FIND:
                if (rd_mark == MK_ACTIVE) found_value <= rd_val_wide[31:0];
                else status <= ohash_pkg::ST_ABSENT;
              ohash_pkg::MODE_INSERT:
                if (rd_mark == MK_ACTIVE) status <= ohash_pkg::ST_PRESENT;
              default:
                if (rd_mark != MK_ACTIVE) status <= ohash_pkg::ST_ABSENT;
            endcase
          end else if (visits == CW'(TABLE_DEPTH - 1)) begin
            status <= ohash_pkg::ST_FULL;
            state  <= S_OUT;
          end else begin
            visits <= visits + 1'b1;
            pos    <= pos_next;
            state  <= S_READ;
          end
        end
        S_CLEAR: begin
          pos <= pos_next;
          if (pos == AW'(TABLE_DEPTH - 1)) begin
            status      <= ohash_pkg::ST_DONE;
            found_value <= nfv;
            state       <= S_OUT;
          end
        end
        S_OUT: if (pop) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/open_addressing_hash_table.sv
`default_nettype none
// channel   direction  handshake            payload
// request   in         push / full          mode, lookup_key, entry_value
// result    out        pop / empty          status, found_value
// config    in         cfg_valid/cfg_ready  cfg_data (not_found_value)
//
// find/insert/remove: each probe passes through a read state and a check state (the
// registered read of the slot arrays sets the probe loop), starting at the home slot
// clear: one slot a cycle through the mark array
// after reset a clearing pass over every slot runs before the first
// request; two requests queue in front meanwhile
// an unread result stalls the probe engine, not the request queue
module open_addressing_hash_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [1:0]                     mode,
  input  wire logic [ohash_pkg::KEY_BITS-1:0] lookup_key,
  input  wire logic [VALUE_BITS-1:0]          entry_value,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [1:0]                          status,
  output logic [ohash_pkg::NFV_BITS-1:0]      found_value,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ohash_pkg::NFV_BITS-1:0] cfg_data
);

  logic                              req_valid;
  logic                              req_take;
  ohash_pkg::req_t                   req;
  logic [ohash_pkg::NFV_BITS-1:0]    nfv;
  ohash_pkg::status_t                st;

  assign cfg_ready = 1'b1;
  assign status    = st;

  // not-found register
  always_ff @(posedge clk) begin
    if (rst) nfv <= '0;
    else if (cfg_valid) nfv <= cfg_data;
  end

  ohash_front #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .push, .full,
    .mode(ohash_pkg::mode_t'(mode)), .lookup_key, .entry_value,
    .req_valid, .req, .req_take
  );

  ohash_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .req_valid, .req, .req_take, .nfv,
    .empty, .pop, .status(st), .found_value
  );

endmodule
`default_nettype wire

### hw/rtl/ohash_checker.sv
`default_nettype none
// port-level checks
module ohash_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  status,
  input wire logic [31:0] found_value
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(found_value)))
    else $error("result changed while waiting");

  // one result per transaction, so a taken result leaves the queue empty
  a_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("result repeated");

  // reset leaves nothing pending
  a_reset: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not clean after reset");

  // a table-full result still carries a known value
  a_nohit: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == 2'd3) |-> !$isunknown(found_value))
    else $error("full result without value");

endmodule

bind open_addressing_hash_table ohash_checker u_ohash_checker (
  .clk, .rst, .full, .empty, .pop, .status, .found_value
);
`default_nettype wire
